[design/ptp_pkg.sv]
// ----------------------------------------------------------------------------
// ptp_pkg
// Types and constants shared by the periodic task timer pool.
// ----------------------------------------------------------------------------
`default_nettype none

package ptp_pkg;

  localparam int DIV_W = 32;

  localparam logic [1:0] REQ_START     = 2'd0;
  localparam logic [1:0] REQ_START_PWM = 2'd1;
  localparam logic [1:0] REQ_STOP      = 2'd2;
  localparam logic [1:0] REQ_EXPIRY    = 2'd3;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_RUNNING = 2'd1;
  localparam logic [1:0] ST_NO_FREE = 2'd2;
  localparam logic [1:0] ST_RANGE   = 2'd3;

  localparam logic [2:0] TASK_NONE  = 3'd0;
  localparam logic [2:0] TASK_SP    = 3'd1;
  localparam logic [2:0] TASK_FP    = 3'd2;
  localparam logic [2:0] TASK_PROBE = 3'd4;
  localparam logic [2:0] TASK_DAC   = 3'd5;

  localparam logic [2:0] ACT_NONE  = 3'd0;
  localparam logic [2:0] ACT_SP    = 3'd1;
  localparam logic [2:0] ACT_FP    = 3'd2;
  localparam logic [2:0] ACT_SWEEP = 3'd3;
  localparam logic [2:0] ACT_DAC   = 3'd4;

  localparam logic [8:0]  CLK_SLOW_BASE = 9'd400;
  localparam logic [8:0]  CLK_FAST_BASE = 9'd1;
  localparam logic [11:0] QUS_PER_MS    = 12'd4000;
  localparam logic [6:0]  PCT_FULL      = 7'd100;
  // ceil(2^30 / 100): exact divide by 100 for products below 2^23
  localparam logic [23:0] PCT_RECIP     = 24'd10737419;

  typedef enum logic [1:0] {
    DIV_TICKS,
    DIV_RUNS
  } ptp_div_sel_t;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [1:0]  slot;
    logic [2:0]  task_kind;
    logic [15:0] duration_ms;
    logic [30:0] period_qus;
    logic [6:0]  duty_pct;
  } ptp_in_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [1:0]  slot_used;
    logic        clock_sel;
    logic [1:0]  divider_idx;
    logic [2:0]  expander_idx;
    logic [15:0] compare_out;
    logic [2:0]  action;
    logic        stopped;
  } ptp_out_t;

  typedef struct packed {
    logic         load;
    logic         check;
    logic         srch_clr;
    logic         srch_step;
    logic         range_fail;
    logic         div_go;
    ptp_div_sel_t div_sel;
    logic         div_take;
    logic         duty_take;
    logic         commit;
    logic         publish;
  } ptp_cmd_t;

  typedef struct packed {
    logic start_ok;
    logic hit;
    logic last;
    logic div_done;
    logic pwm;
  } ptp_sts_t;

endpackage

`default_nettype wire

[design/ptp_div.sv]
// ----------------------------------------------------------------------------
// ptp_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module ptp_div
  import ptp_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             go,
  input  wire logic [DIV_W-1:0] dividend,
  input  wire logic [DIV_W-1:0] divisor,
  output logic      [DIV_W-1:0] quot,
  output logic                  done
);

  localparam int CW = $clog2(DIV_W);

  logic [DIV_W-1:0] rem;
  logic [DIV_W-1:0] dvs;
  logic [CW-1:0]    cnt;
  logic             busy;
  logic [DIV_W:0]   trial;
  logic [DIV_W:0]   diff;
  logic             ge;

  always_comb begin
    trial = {rem, quot[DIV_W-1]};
    diff  = trial - {1'b0, dvs};
    ge    = trial >= {1'b0, dvs};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else if (go) begin
      busy <= 1'b1;
      done <= 1'b0;
      cnt  <= '0;
    end else if (busy) begin
      cnt <= cnt + 1'b1;
      if (cnt == CW'(DIV_W - 1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      rem  <= '0;
      quot <= dividend;
      dvs  <= divisor;
    end else if (busy) begin
      rem  <= ge ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
      quot <= {quot[DIV_W-2:0], ge};
    end
  end

endmodule

`default_nettype wire

[design/ptp_datapath.sv]
// ----------------------------------------------------------------------------
// ptp_datapath
// Slot state, prescaler search, shared divider and result registers.
// ----------------------------------------------------------------------------
`default_nettype none

module ptp_datapath
  import ptp_pkg::*;
#(
  parameter int NUM_SLOTS    = 4,
  parameter int COUNTER_SPAN = 65536
) (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire ptp_in_t  req,
  input  wire ptp_cmd_t cmd,
  output ptp_sts_t      sts,
  output ptp_out_t      rsp
);

  logic [2:0]  slot_task         [NUM_SLOTS];
  logic [29:0] slot_runs_left    [NUM_SLOTS];
  logic [15:0] slot_period_ticks [NUM_SLOTS];
  logic [15:0] slot_duty_ticks   [NUM_SLOTS];
  logic [15:0] slot_compare      [NUM_SLOTS];

  ptp_in_t              cur;
  ptp_out_t             res;
  ptp_out_t             res_chk;
  ptp_out_t             res_set;
  logic [5:0]           srch_idx;
  logic [15:0]          ticks;
  logic [29:0]          runs;
  logic [15:0]          duty_t;
  logic                 csel;
  logic [1:0]           didx;
  logic [2:0]           eidx;
  logic [NUM_SLOTS-1:0] free_sel;
  logic [1:0]           free_idx;
  ptp_div_sel_t         div_sel_q;

  logic                 is_start;
  logic                 run_found;
  logic [1:0]           run_idx;
  logic                 free_found;
  logic [1:0]           free_idx_c;
  logic [NUM_SLOTS-1:0] free_sel_c;
  logic [NUM_SLOTS-1:0] hit_sel;
  logic                 slot_ok;
  logic [2:0]           sl_task;
  logic [29:0]          sl_runs;
  logic [15:0]          sl_period;
  logic [15:0]          sl_duty;
  logic [15:0]          sl_cmp;
  logic                 exp_clear;
  logic [2:0]           exp_task;
  logic [15:0]          exp_duty;
  logic [15:0]          exp_cmp_old;
  logic [15:0]          exp_cmp;
  logic [2:0]           exp_act;
  logic [8:0]           base;
  logic [15:0]          m_cur;
  logic [32:0]          lim;
  logic [16:0]          dur_d;
  logic [28:0]          d4000;
  logic [6:0]           duty_c;
  logic [22:0]          dprod;
  logic [22:0]          dprod_q;
  logic [46:0]          duty_mul;
  logic [DIV_W-1:0]     dvd;
  logic [DIV_W-1:0]     dvs;
  logic [DIV_W-1:0]     quot;
  logic                 div_done;

  always_comb begin
    run_found  = 1'b0;
    run_idx    = '0;
    free_found = 1'b0;
    free_idx_c = '0;
    free_sel_c = '0;
    hit_sel    = '0;
    sl_task    = '0;
    sl_runs    = '0;
    sl_period  = '0;
    sl_duty    = '0;
    sl_cmp     = '0;
    for (int s = 0; s < NUM_SLOTS; s++) begin
      if (!run_found && cur.task_kind != TASK_NONE && slot_task[s] == cur.task_kind) begin
        run_found = 1'b1;
        run_idx   = 2'(s);
      end
      if (!free_found && slot_task[s] == TASK_NONE) begin
        free_found    = 1'b1;
        free_idx_c    = 2'(s);
        free_sel_c[s] = 1'b1;
      end
      if (32'(cur.slot) == 32'(s)) begin
        hit_sel[s] = 1'b1;
        sl_task    = slot_task[s];
        sl_runs    = slot_runs_left[s];
        sl_period  = slot_period_ticks[s];
        sl_duty    = slot_duty_ticks[s];
        sl_cmp     = slot_compare[s];
      end
    end
    slot_ok = |hit_sel;
  end

  always_comb begin
    exp_clear   = sl_runs == '0;
    exp_task    = exp_clear ? TASK_NONE : sl_task;
    exp_duty    = exp_clear ? 16'd0 : sl_duty;
    exp_cmp_old = exp_clear ? 16'd0 : sl_cmp;
    exp_cmp     = exp_cmp_old;
    if (exp_duty != 16'd0) begin
      exp_cmp = (exp_cmp_old == exp_duty) ? sl_period - exp_duty : exp_duty;
    end
    case (exp_task)
      TASK_SP:    exp_act = ACT_SP;
      TASK_FP:    exp_act = ACT_FP;
      TASK_PROBE: exp_act = ACT_SWEEP;
      TASK_DAC:   exp_act = ACT_DAC;
      default:    exp_act = ACT_NONE;
    endcase
  end

  always_comb begin
    is_start = cur.req_type == REQ_START || cur.req_type == REQ_START_PWM;
    res_chk  = '0;
    if (is_start) begin
      if (cur.task_kind == TASK_NONE) begin
        res_chk.status = ST_RUNNING;
      end else if (run_found) begin
        res_chk.status    = ST_RUNNING;
        res_chk.slot_used = run_idx;
      end else begin
        res_chk.status = ST_NO_FREE;
      end
    end else begin
      res_chk.slot_used = cur.slot;
      if (slot_ok) begin
        if (cur.req_type == REQ_STOP) begin
          res_chk.stopped = 1'b1;
        end else begin
          res_chk.stopped     = exp_clear;
          res_chk.compare_out = exp_cmp;
          res_chk.action      = exp_act;
        end
      end
    end
  end

  always_comb begin
    res_set = '0;
    if (cmd.range_fail) begin
      res_set.status = ST_RANGE;
    end else begin
      res_set.status       = ST_OK;
      res_set.slot_used    = free_idx;
      res_set.clock_sel    = csel;
      res_set.divider_idx  = didx;
      res_set.expander_idx = eidx;
      res_set.compare_out  = ticks;
    end
  end

  always_comb begin
    base  = srch_idx[5] ? CLK_SLOW_BASE : CLK_FAST_BASE;
    m_cur = (16'(base) * (16'(srch_idx[2:0]) + 16'd1)) << srch_idx[4:3];
    lim   = 33'(m_cur) * 33'(COUNTER_SPAN);
    dur_d = (cur.req_type == REQ_START_PWM) ? {cur.duration_ms, 1'b0}
                                            : {1'b0, cur.duration_ms};
    d4000 = 29'(dur_d) * 29'(QUS_PER_MS);
    duty_c   = (cur.duty_pct > PCT_FULL) ? PCT_FULL : cur.duty_pct;
    dprod    = 23'(duty_c) * 23'(ticks);
    duty_mul = 47'(dprod_q) * 47'(PCT_RECIP);
    case (cmd.div_sel)
      DIV_TICKS: begin
        dvd = DIV_W'(cur.period_qus);
        dvs = DIV_W'(m_cur);
      end
      default: begin
        dvd = DIV_W'(d4000);
        dvs = DIV_W'(cur.period_qus);
      end
    endcase
  end

  assign sts.start_ok = is_start && cur.task_kind != TASK_NONE && !run_found && free_found;
  assign sts.hit      = cur.period_qus != '0 && 33'(cur.period_qus) < lim;
  assign sts.last     = srch_idx == 6'h3f;
  assign sts.div_done = div_done;
  assign sts.pwm      = cur.req_type == REQ_START_PWM;

  ptp_div u_div (
    .clk      (clk),
    .rst      (rst),
    .go       (cmd.div_go),
    .dividend (dvd),
    .divisor  (dvs),
    .quot     (quot),
    .done     (div_done)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int s = 0; s < NUM_SLOTS; s++) begin
        slot_task[s]         <= '0;
        slot_runs_left[s]    <= '0;
        slot_period_ticks[s] <= '0;
        slot_duty_ticks[s]   <= '0;
        slot_compare[s]      <= '0;
      end
    end else if (cmd.check && !is_start) begin
      for (int s = 0; s < NUM_SLOTS; s++) begin
        if (hit_sel[s]) begin
          if (cur.req_type == REQ_STOP || exp_clear) begin
            slot_task[s]       <= '0;
            slot_runs_left[s]  <= '0;
            slot_duty_ticks[s] <= '0;
            slot_compare[s]    <= '0;
          end else begin
            slot_runs_left[s] <= sl_runs - 30'd1;
            slot_compare[s]   <= exp_cmp;
          end
        end
      end
    end else if (cmd.commit) begin
      for (int s = 0; s < NUM_SLOTS; s++) begin
        if (free_sel[s]) begin
          slot_task[s]         <= cur.task_kind;
          slot_runs_left[s]    <= runs;
          slot_period_ticks[s] <= ticks;
          slot_compare[s]      <= ticks;
          slot_duty_ticks[s]   <= sts.pwm ? duty_t : 16'd0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cur <= req;
    end
    if (cmd.srch_clr) begin
      srch_idx <= '0;
      free_sel <= free_sel_c;
      free_idx <= free_idx_c;
    end else if (cmd.srch_step) begin
      srch_idx <= srch_idx + 6'd1;
    end
    if (cmd.div_go) begin
      div_sel_q <= cmd.div_sel;
      if (cmd.div_sel == DIV_TICKS) begin
        csel <= srch_idx[5];
        didx <= srch_idx[4:3];
        eidx <= srch_idx[2:0];
      end
    end
    if (cmd.div_take) begin
      case (div_sel_q)
        DIV_TICKS: ticks <= quot[15:0];
        default:   runs  <= quot[29:0];
      endcase
    end
    dprod_q <= dprod;
    if (cmd.duty_take) begin
      duty_t <= duty_mul[45:30];
    end
    if (cmd.check) begin
      res <= res_chk;
    end else if (cmd.range_fail || cmd.commit) begin
      res <= res_set;
    end
    if (cmd.publish) begin
      rsp <= res;
    end
  end

endmodule

`default_nettype wire

[design/ptp_ctrl.sv]
// ----------------------------------------------------------------------------
// ptp_ctrl
// Request sequencer: check, prescaler search, divisions, PWM duty, commit, output.
// ----------------------------------------------------------------------------
`default_nettype none

module ptp_ctrl
  import ptp_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     in_valid,
  output logic          in_stall,
  output logic          out_valid,
  input  wire logic     out_stall,
  input  wire ptp_sts_t sts,
  output ptp_cmd_t      cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_SEARCH,
    S_TICKS,
    S_RUNS,
    S_DUTY,
    S_COMMIT,
    S_OUT
  } state_t;

  state_t state;
  logic   out_free;

  assign out_free = !out_valid || !out_stall;
  assign in_stall = state != S_IDLE;

  always_comb begin
    cmd         = '0;
    cmd.div_sel = DIV_TICKS;
    case (state)
      S_IDLE:   cmd.load = in_valid;
      S_CHECK: begin
        if (sts.start_ok) cmd.srch_clr = 1'b1;
        else cmd.check = 1'b1;
      end
      S_SEARCH: begin
        if (sts.hit) begin
          cmd.div_go  = 1'b1;
          cmd.div_sel = DIV_TICKS;
        end else if (!sts.last) begin
          cmd.srch_step = 1'b1;
        end else begin
          cmd.range_fail = 1'b1;
        end
      end
      S_TICKS: begin
        cmd.div_take = sts.div_done;
        cmd.div_go   = sts.div_done;
        cmd.div_sel  = DIV_RUNS;
      end
      S_RUNS: begin
        cmd.div_take = sts.div_done;
        cmd.div_sel  = DIV_RUNS;
      end
      S_DUTY:   cmd.duty_take = 1'b1;
      S_COMMIT: cmd.commit = 1'b1;
      S_OUT:    cmd.publish = out_free;
      default:  cmd = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (state == S_OUT && out_free) out_valid <= 1'b1;
      else if (out_valid && !out_stall) out_valid <= 1'b0;
      case (state)
        S_IDLE:   if (in_valid) state <= S_CHECK;
        S_CHECK:  state <= sts.start_ok ? S_SEARCH : S_OUT;
        S_SEARCH: begin
          if (sts.hit) state <= S_TICKS;
          else if (sts.last) state <= S_OUT;
        end
        S_TICKS:  if (sts.div_done) state <= S_RUNS;
        S_RUNS:   if (sts.div_done) state <= sts.pwm ? S_DUTY : S_COMMIT;
        S_DUTY:   state <= S_COMMIT;
        S_COMMIT: state <= S_OUT;
        S_OUT:    if (out_free) state <= S_IDLE;
        default:  state <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

[design/periodic_task_timer_pool.sv]
// ----------------------------------------------------------------------------
// periodic_task_timer_pool
// Four-slot periodic task timer pool with prescaler search and run counts.
// ----------------------------------------------------------------------------
// Stop, expiry and rejected starts: check, then output; no search or division.
// Accepted start: check, search (1 to 64 settings, one setting per cycle), then
// the two divisions on the shared serial divider, a duty step for PWM, commit, output.
// Out-of-range period: result after the full 64-step search.
// One request in flight; the next is taken once the result is registered.
// Reset: synchronous, all slots stopped and cleared.
`default_nettype none

module periodic_task_timer_pool
  import ptp_pkg::*;
#(
  parameter int NUM_SLOTS    = 4,
  parameter int COUNTER_SPAN = 65536
) (
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    req_valid,
  output logic         req_stall,
  input  wire ptp_in_t req,
  output logic         rsp_valid,
  input  wire logic    rsp_stall,
  output ptp_out_t     rsp
);

  ptp_cmd_t cmd;
  ptp_sts_t sts;

  ptp_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (req_valid),
    .in_stall  (req_stall),
    .out_valid (rsp_valid),
    .out_stall (rsp_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  ptp_datapath #(
    .NUM_SLOTS    (NUM_SLOTS),
    .COUNTER_SPAN (COUNTER_SPAN)
  ) u_dp (
    .clk (clk),
    .rst (rst),
    .req (req),
    .cmd (cmd),
    .sts (sts),
    .rsp (rsp)
  );

endmodule

`default_nettype wire

[design/ptp_checker.sv]
// ----------------------------------------------------------------------------
// ptp_checker
// Port-level checks for the periodic task timer pool.
// ----------------------------------------------------------------------------
`default_nettype none

module ptp_checker
  import ptp_pkg::*;
(
  input wire logic     clk,
  input wire logic     rst,
  input wire logic     req_valid,
  input wire logic     req_stall,
  input wire logic     rsp_valid,
  input wire logic     rsp_stall,
  input wire ptp_out_t rsp
);

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid)
    else $error("result beat dropped while stalled");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    req_valid && !req_stall |=> req_stall)
    else $error("request taken while one is in flight");

  a_stop_quiet: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.stopped |-> rsp.action == ACT_NONE && rsp.compare_out == 16'd0)
    else $error("stopped slot reports action or compare");

  a_reject_clean: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.status != ST_OK |-> !rsp.clock_sel && rsp.compare_out == 16'd0)
    else $error("rejected start carries a setting");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !rsp_valid)
    else $error("result valid after reset");

endmodule

bind periodic_task_timer_pool ptp_checker u_ptp_checker (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req_valid),
  .req_stall (req_stall),
  .rsp_valid (rsp_valid),
  .rsp_stall (rsp_stall),
  .rsp       (rsp)
);

`default_nettype wire

[tb/sv/periodic_task_timer_pool_test.sv]
// ----------------------------------------------------------------------------
// periodic_task_timer_pool_test
// Drives start, PWM start, stop and expiry requests into the timer pool and
// checks every response against a behavioral model of the four slots.
// ----------------------------------------------------------------------------
`default_nettype none

module periodic_task_timer_pool_test
  import ptp_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int SLOTS = 4;
  localparam int SPAN = 65536;
  localparam int WATCHDOG_LIMIT = 20000;

  logic     clk;
  logic     rst;
  logic     req_valid;
  logic     req_stall;
  ptp_in_t  req;
  logic     rsp_valid;
  logic     rsp_stall;
  ptp_out_t rsp;

  ptp_out_t expected_rsp_q[$];
  int       errors;
  int       sent_cnt;
  int       checked_cnt;
  int       idle_cycles;
  bit       hold_rsp;
  int       rsp_left;
  int       rsp_wait;

  logic [2:0]  mdl_task[SLOTS];
  logic [29:0] mdl_runs[SLOTS];
  logic [15:0] mdl_period[SLOTS];
  logic [15:0] mdl_duty[SLOTS];
  logic [15:0] mdl_cmp[SLOTS];

  periodic_task_timer_pool u_top (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_stall(req_stall), .req(req),
    .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic ptp_out_t predict_timer_rsp(ptp_in_t r);
    ptp_out_t o;
    int run_s, free_s;
    bit found;
    longint unsigned m, mult, ticks, d, per, duty;
    o = '0;
    per = r.period_qus;
    if (r.req_type == REQ_START || r.req_type == REQ_START_PWM) begin
      run_s = -1;
      free_s = -1;
      mult = 1;
      found = 0;
      for (int s = 0; s < SLOTS; s++) begin
        if (run_s < 0 && r.task_kind != TASK_NONE && mdl_task[s] == r.task_kind) run_s = s;
        if (free_s < 0 && mdl_task[s] == TASK_NONE) free_s = s;
      end
      if (r.task_kind == TASK_NONE) begin
        o.status = ST_RUNNING;
      end else if (run_s >= 0) begin
        o.status = ST_RUNNING;
        o.slot_used = 2'(run_s);
      end else if (free_s < 0) begin
        o.status = ST_NO_FREE;
      end else begin
        for (int i = 0; i < 2 && !found; i++)
          for (int j = 0; j < 4 && !found; j++)
            for (int k = 0; k < 8 && !found; k++) begin
              m = (i ? 400 : 1) * (1 << j) * (k + 1);
              if (per != 0 && per < m * SPAN) begin
                found = 1;
                mult = m;
                o.clock_sel = 1'(i);
                o.divider_idx = 2'(j);
                o.expander_idx = 3'(k);
              end
            end
        if (!found) begin
          o.status = ST_RANGE;
        end else begin
          ticks = (per / mult) & 16'hFFFF;
          d = (r.req_type == REQ_START_PWM) ? r.duration_ms * 2 : r.duration_ms;
          mdl_task[free_s] = r.task_kind;
          mdl_runs[free_s] = 30'((d * 4000) / per);
          mdl_period[free_s] = 16'(ticks);
          mdl_cmp[free_s] = 16'(ticks);
          mdl_duty[free_s] = 0;
          if (r.req_type == REQ_START_PWM) begin
            duty = (r.duty_pct > 100) ? 100 : r.duty_pct;
            mdl_duty[free_s] = 16'((duty * ticks) / 100);
          end
          o.slot_used = 2'(free_s);
          o.compare_out = 16'(ticks);
        end
      end
    end else begin
      o.slot_used = r.slot;
      if (r.req_type == REQ_STOP || mdl_runs[r.slot] == 0) begin
        mdl_task[r.slot] = TASK_NONE;
        mdl_runs[r.slot] = 0;
        mdl_duty[r.slot] = 0;
        mdl_cmp[r.slot] = 0;
        o.stopped = 1'b1;
      end else begin
        mdl_runs[r.slot] = mdl_runs[r.slot] - 30'd1;
      end
      if (r.req_type == REQ_EXPIRY) begin
        case (mdl_task[r.slot])
          TASK_SP:    o.action = ACT_SP;
          TASK_FP:    o.action = ACT_FP;
          TASK_PROBE: o.action = ACT_SWEEP;
          TASK_DAC:   o.action = ACT_DAC;
          default:    o.action = ACT_NONE;
        endcase
        if (mdl_duty[r.slot] != 0)
          mdl_cmp[r.slot] = (mdl_cmp[r.slot] == mdl_duty[r.slot]) ?
                            mdl_period[r.slot] - mdl_duty[r.slot] : mdl_duty[r.slot];
      end
      o.compare_out = mdl_cmp[r.slot];
    end
    return o;
  endfunction

  task automatic send_beat(ptp_in_t r);
    int gap;
    gap = $urandom_range(0, 3);
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_valid <= 1'b1;
    req <= r;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    expected_rsp_q.push_back(predict_timer_rsp(r));
    sent_cnt++;
  endtask

  function automatic ptp_in_t make_req(logic [1:0] rt, logic [1:0] sl, logic [2:0] tk,
                                       logic [15:0] dur, logic [30:0] per,
                                       logic [6:0] duty);
    ptp_in_t r;
    r.req_type = rt;
    r.slot = sl;
    r.task_kind = tk;
    r.duration_ms = dur;
    r.period_qus = per;
    r.duty_pct = duty;
    return r;
  endfunction

  function automatic logic [30:0] rand_period();
    case ($urandom_range(0, 5))
      0: return 31'($urandom_range(1, 65535));
      1: return 31'($urandom_range(65536, 2097151));
      2: return 31'($urandom_range(2097152, 209715199));
      3: return 31'h7FFF_FFFF >> $urandom_range(0, 30);
      4: return $urandom_range(0, 3) == 0 ? 31'd0 : 31'd209715200;
      default: return 31'($urandom);
    endcase
  endfunction

  function automatic ptp_in_t rand_req();
    ptp_in_t r;
    r = '0;
    r.slot = 2'($urandom);
    r.duration_ms = ($urandom_range(0, 3) == 0) ? 16'($urandom)
                                                 : 16'($urandom_range(0, 40));
    r.period_qus = rand_period();
    if ($urandom_range(0, 9) < 8 && r.period_qus > 4000 * 64)
      r.duration_ms = 16'($urandom);
    r.duty_pct = ($urandom_range(0, 4) == 0) ? 7'($urandom) : 7'($urandom_range(0, 100));
    case ($urandom_range(0, 9))
      0, 1, 2: r.req_type = REQ_EXPIRY;
      3:       r.req_type = REQ_STOP;
      4, 5:    r.req_type = REQ_START_PWM;
      default: r.req_type = REQ_START;
    endcase
    if ($urandom_range(0, 15) == 0) r.task_kind = 3'($urandom_range(0, 7));
    else r.task_kind = 3'($urandom_range(1, 5));
    return r;
  endfunction

  task automatic wait_drained();
    req_valid <= 1'b0;
    while (expected_rsp_q.size() != 0) @(posedge clk);
  endtask

  task automatic test_directed_starts();
    send_beat(make_req(REQ_START, 2'd0, TASK_SP, 16'd0, 31'd1, 7'd0));
    send_beat(make_req(REQ_START, 2'd0, TASK_SP, 16'd10, 31'd100, 7'd0));
    send_beat(make_req(REQ_START, 2'd0, TASK_NONE, 16'd10, 31'd100, 7'd0));
    send_beat(make_req(REQ_START_PWM, 2'd0, TASK_FP, 16'hFFFF, 31'd65535, 7'd50));
    send_beat(make_req(REQ_START_PWM, 2'd0, 3'd6, 16'd3, 31'd65536, 7'd127));
    send_beat(make_req(REQ_START, 2'd0, 3'd7, 16'd3, 31'd4000, 7'd0));
    send_beat(make_req(REQ_START, 2'd0, TASK_DAC, 16'd3, 31'd4000, 7'd0));
    send_beat(make_req(REQ_STOP, 2'd3, TASK_SP, 16'd0, 31'd1, 7'd0));
    send_beat(make_req(REQ_START, 2'd0, TASK_DAC, 16'd0, 31'd0, 7'd0));
    send_beat(make_req(REQ_START, 2'd0, TASK_DAC, 16'd0, 31'h7FFF_FFFF, 7'd0));
    send_beat(make_req(REQ_START, 2'd0, TASK_DAC, 16'd0, 31'd209715199, 7'd0));
    send_beat(make_req(REQ_START_PWM, 2'd0, TASK_PROBE, 16'd1, 31'd209715200, 7'd100));
    wait_drained();
  endtask

  task automatic test_directed_expiry();
    for (int s = 0; s < SLOTS; s++)
      repeat (3) send_beat(make_req(REQ_EXPIRY, 2'(s), 3'd0, 16'd0, 31'd1, 7'd0));
    for (int s = 0; s < SLOTS; s++)
      send_beat(make_req(REQ_STOP, 2'(s), 3'd0, 16'd0, 31'd1, 7'd0));
    send_beat(make_req(REQ_EXPIRY, 2'd1, 3'd0, 16'd0, 31'd1, 7'd0));
    wait_drained();
  endtask

  task automatic test_random_mix(int n);
    for (int i = 0; i < n; i++) send_beat(rand_req());
    wait_drained();
  endtask

  task automatic test_backpressure();
    hold_rsp = 1'b1;
    for (int i = 0; i < 12; i++) send_beat(make_req(REQ_EXPIRY, 2'(i % 4), 3'd0, 16'd0,
                                                    31'd1, 7'd0));
    wait_drained();
  endtask

  always @(posedge clk) begin
    if (rst) begin
      rsp_stall <= 1'b0;
      rsp_left <= 0;
    end else begin
      if (hold_rsp) begin
        rsp_stall <= 1'b1;
        repeat (300) @(posedge clk);
        hold_rsp = 1'b0;
        rsp_stall <= 1'b0;
        rsp_left <= 0;
      end else if (rsp_valid && !rsp_stall) begin
        rsp_wait = $urandom_range(0, 3);
        rsp_stall <= (rsp_wait != 0);
        rsp_left <= rsp_wait;
      end else if (rsp_left > 1) begin
        rsp_left <= rsp_left - 1;
      end else begin
        rsp_stall <= 1'b0;
        rsp_left <= 0;
      end
    end
  end

  always @(posedge clk) begin
    ptp_out_t e;
    if (!rst && rsp_valid && !rsp_stall) begin
      if (expected_rsp_q.size() == 0) begin
        $error("response with nothing expected: %p", rsp);
        errors++;
      end else begin
        e = expected_rsp_q.pop_front();
        checked_cnt++;
        if (rsp.status !== e.status) begin
          $error("status exp %0d got %0d", e.status, rsp.status); errors++;
        end
        if (rsp.slot_used !== e.slot_used) begin
          $error("slot_used exp %0d got %0d", e.slot_used, rsp.slot_used); errors++;
        end
        if (rsp.clock_sel !== e.clock_sel) begin
          $error("clock_sel exp %0d got %0d", e.clock_sel, rsp.clock_sel); errors++;
        end
        if (rsp.divider_idx !== e.divider_idx) begin
          $error("divider_idx exp %0d got %0d", e.divider_idx, rsp.divider_idx); errors++;
        end
        if (rsp.expander_idx !== e.expander_idx) begin
          $error("expander_idx exp %0d got %0d", e.expander_idx, rsp.expander_idx);
          errors++;
        end
        if (rsp.compare_out !== e.compare_out) begin
          $error("compare_out exp %0d got %0d", e.compare_out, rsp.compare_out); errors++;
        end
        if (rsp.action !== e.action) begin
          $error("action exp %0d got %0d", e.action, rsp.action); errors++;
        end
        if (rsp.stopped !== e.stopped) begin
          $error("stopped exp %0d got %0d", e.stopped, rsp.stopped); errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("Some tests failed");
        $finish;
      end
    end
  end

  initial begin
    errors = 0;
    sent_cnt = 0;
    checked_cnt = 0;
    idle_cycles = 0;
    hold_rsp = 1'b0;
    rst <= 1'b1;
    req_valid <= 1'b0;
    req <= '0;
    for (int s = 0; s < SLOTS; s++) begin
      mdl_task[s] = 0; mdl_runs[s] = 0; mdl_period[s] = 0;
      mdl_duty[s] = 0; mdl_cmp[s] = 0;
    end
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed_starts();
    test_directed_expiry();
    test_random_mix(200);
    test_backpressure();
    test_random_mix(240);
    repeat (200) @(posedge clk);
    $display("Sent %0d requests (starts, PWM starts, stops, expiries), checked %0d responses.",
             sent_cnt, checked_cnt);
    if (errors == 0 && expected_rsp_q.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
